// File: hw/rtl/mfd_pkg.sv
package mfd_pkg;

	// Frame length in bits and limits of the configurable range.
	localparam int FRAME_BITS_DEF = 23;
	localparam int FRAME_BITS_MIN = 17;
	localparam int FRAME_BITS_MAX = 32;

	localparam int TICK_W    = 16;
	localparam int HBC_W     = 8;
	localparam int BITCNT_W  = 5;
	localparam int HDR_W     = 7;
	localparam int BYTE_W    = 8;
	localparam int RPT_W     = 8;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 4;

	// Register reset values.
	localparam logic [TICK_W-1:0] MIN_HALF_RST = 16'd460;
	localparam logic [TICK_W-1:0] MAX_HALF_RST = 16'd540;
	localparam logic [TICK_W-1:0] MAX_BIT_RST  = 16'd1080;

	// Header checks: start pattern and complementary toggle pair.
	localparam logic [HDR_W-1:0] HDR_START_MASK = 7'h7C;
	localparam logic [HDR_W-1:0] HDR_START_VAL  = 7'h64;
	localparam logic [HDR_W-1:0] HDR_TOG_MASK   = 7'h03;
	localparam logic [HDR_W-1:0] HDR_TOG_ZERO   = 7'h01;
	localparam logic [HDR_W-1:0] HDR_TOG_ONE    = 7'h02;

	// Register index, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_MIN_HALF = 2'd0,
		REG_MAX_HALF = 2'd1,
		REG_MAX_BIT  = 2'd2
	} reg_idx_t;

endpackage

// File: hw/rtl/manchester_frame_decoder_core.sv
// Manchester frame decoder. Each input item is one captured line edge with a
// free-running 16-bit timestamp and the consumer's busy flag; each item yields
// exactly one result item telling the capture unit which edge to watch next,
// plus the data byte, toggle bit and repeat count of a frame completed by that
// edge. Pulse widths are the timestamp difference modulo 65536 and are judged
// against three thresholds written over the APB port (offsets 0x0, 0x4, 0x8),
// used exactly as written even if they are inconsistent. A new item is
// accepted in every cycle while in_stall is low: it is held in an input
// register, then the decode step updates the frame state and loads the result
// register. The rate of one item per cycle, barring stalls, is set by that
// decode step, whose state feeds back into itself for the following edge.
// The result register holds a result while out_stall is high; the input
// register then takes one more item only if it is empty, and in_stall rises
// once it holds one. Frames whose completion meets a busy consumer are
// dropped and leave the repeat counter untouched. The frame length is set
// by the FRAME_BITS parameter (17 to 32); the header always sits at bits 22..16.
module manchester_frame_decoder_core
	import mfd_pkg::*;
#(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Edge items in
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [TICK_W-1:0]   capture_time,
	input  logic                consumer_busy,
	// Result items out
	output logic                out_valid,
	input  logic                out_stall,
	output logic                next_edge_rising,
	output logic                frame_valid,
	output logic [BYTE_W-1:0]   data_byte,
	output logic                toggle,
	output logic [RPT_W-1:0]    repeat_count,
	// Configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	localparam int CNT_W = BITCNT_W + 1;

	// Threshold registers.
	logic [TICK_W-1:0] min_half_q, max_half_q, max_bit_q;

	// Input register.
	logic              valid_s1;
	logic [TICK_W-1:0] cap_s1;
	logic              busy_s1;

	// Decoder state.
	logic [TICK_W-1:0]     last_cap_q;
	logic                  edge_sel_q;
	logic [HBC_W-1:0]      hbc_q;
	logic                  frame_ok_q;
	logic [FRAME_BITS-1:0] word_q;
	logic [BITCNT_W-1:0]   bits_q;
	logic [HDR_W-1:0]      last_hdr_q;
	logic [RPT_W-1:0]      rpt_q;

	// Next-state and result of the decode step.
	logic [TICK_W-1:0]     width;
	logic                  edge_sel_d;
	logic [HBC_W-1:0]      hbc_d;
	logic                  frame_ok_d;
	logic [FRAME_BITS-1:0] word_d;
	logic [FRAME_BITS-1:0] word_sh;
	logic [BITCNT_W-1:0]   bits_d;
	logic [HDR_W-1:0]      last_hdr_d;
	logic [RPT_W-1:0]      rpt_d;
	logic [CNT_W-1:0]      cnt;
	logic [31:0]           word_ext;
	logic [HDR_W-1:0]      hdr;
	logic [BYTE_W-1:0]     byte_val;
	logic [BYTE_W-1:0]     inv_val;
	logic                  valid_d;
	logic [BYTE_W-1:0]     data_d;
	logic                  tog_d;

	logic advance;
	logic wr_en;

	// The step advances when the result register is free or being emptied.
	assign advance  = ~out_valid | ~out_stall;
	assign in_stall = valid_s1 & ~advance;

	// ---------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_half_q <= MIN_HALF_RST;
			max_half_q <= MAX_HALF_RST;
			max_bit_q  <= MAX_BIT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_MIN_HALF: min_half_q <= pwdata[TICK_W-1:0];
				REG_MAX_HALF: max_half_q <= pwdata[TICK_W-1:0];
				REG_MAX_BIT:  max_bit_q  <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MIN_HALF: prdata = APB_DW'(min_half_q);
			REG_MAX_HALF: prdata = APB_DW'(max_half_q);
			REG_MAX_BIT:  prdata = APB_DW'(max_bit_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cap_s1  <= capture_time;
			busy_s1 <= consumer_busy;
		end
	end

	// ---------------------------------------------------------------
	// Decode step
	// ---------------------------------------------------------------

	// The word as it looks once this edge's polarity is shifted in.
	assign word_sh = {word_q[FRAME_BITS-2:0], ~edge_sel_q};

	always_comb begin
		width      = cap_s1 - last_cap_q;
		edge_sel_d = ~edge_sel_q;
		hbc_d      = hbc_q;
		frame_ok_d = frame_ok_q;
		word_d     = word_q;
		bits_d     = bits_q;
		last_hdr_d = last_hdr_q;
		rpt_d      = rpt_q;
		cnt        = CNT_W'(bits_q) + CNT_W'(1);
		valid_d    = 1'b0;
		data_d     = '0;
		tog_d      = 1'b0;

		// A long gap resynchronizes to a frame start.
		if (width > max_bit_q) begin
			hbc_d = '0;
		end

		if (hbc_d == '0) begin
			word_d     = '0;
			bits_d     = '0;
			edge_sel_d = 1'b1;
			hbc_d      = HBC_W'(1);
			frame_ok_d = 1'b1;
		end else if (frame_ok_q) begin
			if (width < min_half_q || width > max_bit_q) begin
				frame_ok_d = 1'b0;
			end
			if (frame_ok_d) begin
				// A full-bit width skips one half-bit.
				if (width > max_half_q) begin
					hbc_d = hbc_d + HBC_W'(1);
				end
				if (!hbc_d[0]) begin
					word_d = word_sh;
					bits_d = cnt[BITCNT_W-1:0];
					if (cnt == CNT_W'(FRAME_BITS)) begin
						if (!busy_s1) begin
							if (hdr == last_hdr_q) begin
								rpt_d = rpt_q + RPT_W'(1);
							end else begin
								rpt_d = '0;
							end
							last_hdr_d = hdr;
							if (inv_val == byte_val &&
							    (hdr & HDR_START_MASK) == HDR_START_VAL &&
							    ((hdr & HDR_TOG_MASK) == HDR_TOG_ZERO ||
							     (hdr & HDR_TOG_MASK) == HDR_TOG_ONE)) begin
								valid_d = 1'b1;
								data_d  = byte_val;
								tog_d   = hdr[0];
							end
						end
						// A completed frame always restarts reception.
						frame_ok_d = 1'b0;
					end
				end
				hbc_d = hbc_d + HBC_W'(1);
			end
		end

		if (!frame_ok_d) begin
			hbc_d      = '0;
			edge_sel_d = 1'b0;
		end
	end

	// Fields of the freshly shifted word.
	assign word_ext = 32'(word_sh);
	assign hdr      = word_ext[22:16];
	assign byte_val = word_ext[15:8];
	assign inv_val  = ~word_ext[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cap_q <= '0;
			edge_sel_q <= 1'b0;
			hbc_q      <= '0;
			frame_ok_q <= 1'b0;
			word_q     <= '0;
			bits_q     <= '0;
			last_hdr_q <= '0;
			rpt_q      <= '0;
		end else if (valid_s1 && advance) begin
			last_cap_q <= cap_s1;
			edge_sel_q <= edge_sel_d;
			hbc_q      <= hbc_d;
			frame_ok_q <= frame_ok_d;
			word_q     <= word_d;
			bits_q     <= bits_d;
			last_hdr_q <= last_hdr_d;
			rpt_q      <= rpt_d;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			next_edge_rising <= edge_sel_d;
			frame_valid      <= valid_d;
			data_byte        <= data_d;
			toggle           <= tog_d;
			repeat_count     <= rpt_d;
		end
	end

endmodule

// File: hw/rtl/mfd_checker.sv
module mfd_checker
	import mfd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              next_edge_rising,
	input logic              frame_valid,
	input logic [BYTE_W-1:0] data_byte,
	input logic              toggle,
	input logic [RPT_W-1:0]  repeat_count
);

	// A completed frame always ends reception, so the falling edge is next.
	a_valid_frame_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_valid |-> !next_edge_rising)
		else $error("valid frame without restart");

	// Byte and toggle are cleared unless a frame passed its checks.
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_valid |-> data_byte == '0 && !toggle)
		else $error("data fields set without a valid frame");

	// A result appearing on an empty output comes from an accepted item that passed through the input register.
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted item");

	// A stalled result holds.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_valid) &&
			$stable(data_byte) && $stable(repeat_count) && $stable(next_edge_rising))
		else $error("stalled result changed");

endmodule

bind manchester_frame_decoder_core mfd_checker u_mfd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.next_edge_rising (next_edge_rising),
	.frame_valid      (frame_valid),
	.data_byte        (data_byte),
	.toggle           (toggle),
	.repeat_count     (repeat_count)
);
